// ----- design/smbpec_pkg.sv -----
package smbpec_pkg;

    // pec crc-8 constants
    localparam logic [7:0] PEC_POLY = 8'h07;
    localparam logic [7:0] PEC_INIT = 8'h00;
    localparam logic [7:0] PEC_TOP  = 8'h80;

    // function codes
    localparam logic FUNC_BEGIN = 1'b0;
    localparam logic FUNC_DATA  = 1'b1;

    // transaction kinds
    localparam logic [2:0] KIND_SEND    = 3'd0;
    localparam logic [2:0] KIND_RECV    = 3'd1;
    localparam logic [2:0] KIND_WR_BYTE = 3'd2;
    localparam logic [2:0] KIND_RD_BYTE = 3'd3;
    localparam logic [2:0] KIND_BLK_WR  = 3'd4;
    localparam logic [2:0] KIND_BLK_RD  = 3'd5;

    // byte roles
    localparam logic [1:0] ROLE_TX     = 2'd0;
    localparam logic [1:0] ROLE_RXDATA = 2'd1;
    localparam logic [1:0] ROLE_RXCNT  = 2'd2;
    localparam logic [1:0] ROLE_STATUS = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_PEC_ERR  = 3'd1;
    localparam logic [2:0] ST_OVER_CAP = 3'd2;
    localparam logic [2:0] ST_ZERO_LEN = 3'd3;
    localparam logic [2:0] ST_UNEXP    = 3'd4;

    // register indexes
    localparam logic [1:0] REG_PEC_ENABLE = 2'd0;

    typedef struct packed {
        logic       func;
        logic [2:0] kind;
        logic [6:0] target_addr;
        logic [7:0] command_code;
        logic [7:0] byte_count;
        logic [7:0] data_byte;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] byte_role;
        logic [2:0] status;
        logic       last;
    } t_out_beat;

    function automatic logic [7:0] crc_fold(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] c;
        c = acc ^ b;
        for (int i = 0; i < 8; i++) begin
            if ((c & PEC_TOP) != 8'h00) begin
                c = (c << 1) ^ PEC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

    function automatic t_out_beat mk_beat(input logic [7:0] b, input logic [1:0] role,
                                          input logic [2:0] st, input logic lst);
        t_out_beat r;
        r.out_byte  = b;
        r.byte_role = role;
        r.status    = st;
        r.last      = lst;
        return r;
    endfunction

endpackage

// ----- design/smbus_pec_frame_engine.sv -----
// smbus frame builder and checker with pec (crc-8, poly 0x07, init 0)
// an accepted beat is held in the input register; once the output queue has room for two results,
//   the beat is processed and its results are written into the queue, where the first one is valid
// throughput: one input beat per cycle while o_in_stall is low; the output port moves one result
//   per cycle while i_out_stall is low, so an item with two results takes two transfers; the queue
//   absorbs the difference and the input stalls while more than OQ_DEPTH-2 results wait; reset:
//   synchronous active-low i_rst_n clears the frame state, pec_enable and the output queue
module smbus_pec_frame_engine #(
    parameter int OQ_DEPTH = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    // input channel
    input  logic                    i_in_valid,
    input  smbpec_pkg::t_in_beat    i_in_data,
    output logic                    o_in_stall,

    // result channel
    output logic                    o_out_valid,
    output smbpec_pkg::t_out_beat   o_out_beat,
    input  logic                    i_out_stall,

    // register port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [1:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int PTR_W = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(OQ_DEPTH + 1);

    // frame phases, one-hot
    typedef enum logic [6:0] {
        PH_IDLE    = 7'b0000001,
        PH_SEND    = 7'b0000010,
        PH_RXDATA  = 7'b0000100,
        PH_RXPEC   = 7'b0001000,
        PH_BWDATA  = 7'b0010000,
        PH_BRCOUNT = 7'b0100000,
        PH_BRDATA  = 7'b1000000
    } t_phase;

    // ------------------------------------------------------------------
    // register port: single pec_enable bit, no wait states
    // ------------------------------------------------------------------
    logic r_pec_en;

    assign pready = 1'b1;
    assign prdata = {31'd0, r_pec_en};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pec_en <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && paddr == smbpec_pkg::REG_PEC_ENABLE) begin
            r_pec_en <= pwdata[0];
        end
    end

    // ------------------------------------------------------------------
    // input register stage
    // ------------------------------------------------------------------
    logic                 r_in_vld;
    smbpec_pkg::t_in_beat r_in;
    logic                 oq_room;   // queue can take two results
    logic                 adv;       // registered beat is processed this cycle
    logic                 in_acc;

    assign adv        = r_in_vld && oq_room;
    assign o_in_stall = r_in_vld && !oq_room;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_acc) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
    end

    // ------------------------------------------------------------------
    // frame state
    // ------------------------------------------------------------------
    t_phase     r_phase,      n_phase;
    logic [7:0] r_crc,        n_crc;
    logic [7:0] r_bytes_left, n_bytes_left;
    logic [7:0] r_capacity,   n_capacity;

    smbpec_pkg::t_out_beat res0, res1;
    logic [1:0]            res_n;     // number of results this beat makes

    // address bytes with write and read bit
    logic [7:0] addr_wr, addr_rd;
    logic [7:0] crc_aw, crc_ar, crc_aw_cmd, crc_dat;
    logic [7:0] bl_dec;

    assign addr_wr    = {r_in.target_addr, 1'b0};
    assign addr_rd    = {r_in.target_addr, 1'b1};
    assign crc_aw     = smbpec_pkg::crc_fold(smbpec_pkg::PEC_INIT, addr_wr);
    assign crc_ar     = smbpec_pkg::crc_fold(smbpec_pkg::PEC_INIT, addr_rd);
    assign crc_aw_cmd = smbpec_pkg::crc_fold(crc_aw, r_in.command_code);
    assign crc_dat    = smbpec_pkg::crc_fold(r_crc, r_in.data_byte);
    assign bl_dec     = r_bytes_left - 8'd1;

    always_comb begin
        n_phase      = r_phase;
        n_crc        = r_crc;
        n_bytes_left = r_bytes_left;
        n_capacity   = r_capacity;
        res_n        = 2'd0;
        res0         = smbpec_pkg::mk_beat(8'h00, smbpec_pkg::ROLE_STATUS,
                                           smbpec_pkg::ST_UNEXP, 1'b1);
        res1         = res0;

        if (r_in.func == smbpec_pkg::FUNC_BEGIN) begin
            // a begin always drops whatever transaction was running
            n_phase      = PH_IDLE;
            n_bytes_left = 8'd0;
            if (r_in.kind > smbpec_pkg::KIND_BLK_RD) begin
                res_n = 2'd1;
            end else if ((r_in.kind == smbpec_pkg::KIND_BLK_WR
                          || r_in.kind == smbpec_pkg::KIND_BLK_RD)
                         && r_in.byte_count == 8'd0) begin
                res_n = 2'd1;
                res0  = smbpec_pkg::mk_beat(8'h00, smbpec_pkg::ROLE_STATUS,
                                            smbpec_pkg::ST_ZERO_LEN, 1'b1);
            end else begin
                res0 = smbpec_pkg::mk_beat(r_in.command_code, smbpec_pkg::ROLE_TX,
                                           smbpec_pkg::ST_OK, 1'b0);
                res1 = smbpec_pkg::mk_beat(r_in.byte_count, smbpec_pkg::ROLE_TX,
                                           smbpec_pkg::ST_OK, 1'b0);
                unique case (r_in.kind)
                    smbpec_pkg::KIND_SEND: begin
                        n_crc   = crc_aw;
                        n_phase = PH_SEND;
                    end
                    smbpec_pkg::KIND_RECV: begin
                        n_crc   = crc_ar;
                        n_phase = PH_RXDATA;
                    end
                    smbpec_pkg::KIND_WR_BYTE: begin
                        n_crc   = crc_aw_cmd;
                        n_phase = PH_SEND;
                        res_n   = 2'd1;
                    end
                    smbpec_pkg::KIND_RD_BYTE: begin
                        n_crc   = smbpec_pkg::crc_fold(crc_aw_cmd, addr_rd);
                        n_phase = PH_RXDATA;
                        res_n   = 2'd1;
                    end
                    smbpec_pkg::KIND_BLK_WR: begin
                        n_crc        = smbpec_pkg::crc_fold(crc_aw_cmd, r_in.byte_count);
                        n_bytes_left = r_in.byte_count;
                        n_phase      = PH_BWDATA;
                        res_n        = 2'd2;
                    end
                    default: begin
                        // block read
                        n_crc      = smbpec_pkg::crc_fold(crc_aw_cmd, addr_rd);
                        n_capacity = r_in.byte_count;
                        n_phase    = PH_BRCOUNT;
                        res_n      = 2'd1;
                    end
                endcase
            end
        end else begin
            res_n = 2'd1;
            unique case (r_phase)
                PH_SEND: begin
                    n_crc   = crc_dat;
                    n_phase = PH_IDLE;
                    res0    = smbpec_pkg::mk_beat(r_in.data_byte, smbpec_pkg::ROLE_TX,
                                                  smbpec_pkg::ST_OK, !r_pec_en);
                    res1    = smbpec_pkg::mk_beat(crc_dat, smbpec_pkg::ROLE_TX,
                                                  smbpec_pkg::ST_OK, 1'b1);
                    res_n   = r_pec_en ? 2'd2 : 2'd1;
                end
                PH_RXDATA: begin
                    n_crc   = crc_dat;
                    n_phase = r_pec_en ? PH_RXPEC : PH_IDLE;
                    res0    = smbpec_pkg::mk_beat(r_in.data_byte, smbpec_pkg::ROLE_RXDATA,
                                                  smbpec_pkg::ST_OK, !r_pec_en);
                end
                PH_RXPEC: begin
                    n_phase = PH_IDLE;
                    res0    = smbpec_pkg::mk_beat(r_in.data_byte, smbpec_pkg::ROLE_STATUS,
                                                  (r_in.data_byte == r_crc)
                                                      ? smbpec_pkg::ST_OK
                                                      : smbpec_pkg::ST_PEC_ERR,
                                                  1'b1);
                end
                PH_BWDATA: begin
                    n_crc        = crc_dat;
                    n_bytes_left = bl_dec;
                    if (bl_dec != 8'd0) begin
                        res0 = smbpec_pkg::mk_beat(r_in.data_byte, smbpec_pkg::ROLE_TX,
                                                   smbpec_pkg::ST_OK, 1'b0);
                    end else begin
                        n_phase = PH_IDLE;
                        res0    = smbpec_pkg::mk_beat(r_in.data_byte, smbpec_pkg::ROLE_TX,
                                                      smbpec_pkg::ST_OK, !r_pec_en);
                        res1    = smbpec_pkg::mk_beat(crc_dat, smbpec_pkg::ROLE_TX,
                                                      smbpec_pkg::ST_OK, 1'b1);
                        res_n   = r_pec_en ? 2'd2 : 2'd1;
                    end
                end
                PH_BRCOUNT: begin
                    if (r_in.data_byte > r_capacity) begin
                        // count over capacity ends the transaction
                        n_phase      = PH_IDLE;
                        n_bytes_left = 8'd0;
                        res0 = smbpec_pkg::mk_beat(r_in.data_byte, smbpec_pkg::ROLE_RXCNT,
                                                   smbpec_pkg::ST_OVER_CAP, 1'b1);
                    end else begin
                        n_crc        = crc_dat;
                        n_bytes_left = r_in.data_byte;
                        if (r_in.data_byte != 8'd0) begin
                            n_phase = PH_BRDATA;
                        end else begin
                            n_phase = r_pec_en ? PH_RXPEC : PH_IDLE;
                        end
                        res0 = smbpec_pkg::mk_beat(r_in.data_byte, smbpec_pkg::ROLE_RXCNT,
                                                   smbpec_pkg::ST_OK,
                                                   r_in.data_byte == 8'd0 && !r_pec_en);
                    end
                end
                PH_BRDATA: begin
                    n_crc        = crc_dat;
                    n_bytes_left = bl_dec;
                    if (bl_dec != 8'd0) begin
                        res0 = smbpec_pkg::mk_beat(r_in.data_byte, smbpec_pkg::ROLE_RXDATA,
                                                   smbpec_pkg::ST_OK, 1'b0);
                    end else begin
                        n_phase = r_pec_en ? PH_RXPEC : PH_IDLE;
                        res0    = smbpec_pkg::mk_beat(r_in.data_byte,
                                                      smbpec_pkg::ROLE_RXDATA,
                                                      smbpec_pkg::ST_OK, !r_pec_en);
                    end
                end
                default: begin
                    // data beat with no transaction open
                    n_phase      = PH_IDLE;
                    n_bytes_left = 8'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_crc        <= smbpec_pkg::PEC_INIT;
            r_bytes_left <= 8'd0;
            r_capacity   <= 8'd0;
        end else if (adv) begin
            r_phase      <= n_phase;
            r_crc        <= n_crc;
            r_bytes_left <= n_bytes_left;
            r_capacity   <= n_capacity;
        end
    end

    // ------------------------------------------------------------------
    // output queue: takes up to two results per cycle and, while i_out_stall is low, drains one
    // ------------------------------------------------------------------
    smbpec_pkg::t_out_beat oq_mem [OQ_DEPTH];
    logic [PTR_W-1:0]      r_wp, r_rp;
    logic [CNT_W-1:0]      r_count;
    logic [PTR_W-1:0]      wp1, wp2, rp1;
    logic [1:0]            wr_n;
    logic                  pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(OQ_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign wp1     = ptr_inc(r_wp);
    assign wp2     = ptr_inc(wp1);
    assign rp1     = ptr_inc(r_rp);
    assign wr_n    = adv ? res_n : 2'd0;
    assign oq_room = r_count <= CNT_W'(OQ_DEPTH - 2);

    assign o_out_valid = r_count != '0;
    assign o_out_beat  = oq_mem[r_rp];
    assign pop         = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (wr_n != 2'd0) begin
            oq_mem[r_wp] <= res0;
        end
        if (wr_n == 2'd2) begin
            oq_mem[wp1] <= res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            unique case (wr_n)
                2'd2:    r_wp <= wp2;
                2'd1:    r_wp <= wp1;
                default: r_wp <= r_wp;
            endcase
            if (pop) begin
                r_rp <= rp1;
            end
            r_count <= r_count + CNT_W'(wr_n) - CNT_W'(pop);
        end
    end

`ifndef SYNTHESIS
    // queue never overfills
    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(OQ_DEPTH))
        else $error("output queue overflow");

    // block write data phase always has bytes still to send
    a_bw_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_BWDATA |-> r_bytes_left != 8'd0)
        else $error("block write phase with zero bytes left");

    // block read data phase always has bytes still to receive
    a_br_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_BRDATA |-> r_bytes_left != 8'd0)
        else $error("block read phase with zero bytes left");

    // an unknown kind never opens a transaction
    a_bad_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in.func == smbpec_pkg::FUNC_BEGIN && r_in.kind > smbpec_pkg::KIND_BLK_RD)
        |=> r_phase == PH_IDLE)
        else $error("unknown kind opened a transaction");
`endif

endmodule
